[rtl/core/cdwm_pkg.sv]
// ----------------------------------------------------------------------------
// cdwm_pkg: shared types and constants
// Register indexes, widths, gray table and controller/datapath links.
// ----------------------------------------------------------------------------
package cdwm_pkg;

  localparam int MaxWidth  = 1024;
  localparam int LineDepth = MaxWidth + 1;
  localparam int AddrW     = $clog2(LineDepth);
  localparam int DistW     = 13;
  localparam int ColW      = 15;
  localparam int TotW      = 17;
  localparam logic [DistW-1:0] OneQ12 = 13'd4096;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_REF  = 3'd1;
  localparam logic [2:0] REG_W0   = 3'd2;
  localparam logic [2:0] REG_W1   = 3'd3;
  localparam logic [2:0] REG_W2   = 3'd4;
  localparam logic [2:0] REG_FW   = 3'd5;
  localparam logic [2:0] REG_FH   = 3'd6;

  typedef struct packed {
    logic       mode;
    logic [23:0] ref_col;
    logic [7:0] w0;
    logic [7:0] w1;
    logic [7:0] w2;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic             start;     // pixel beat accepted, start distance
    logic             commit;    // write lines, shift window, build result
    logic             pad;
    logic             top_valid; // row >= 2
    logic             col_zero;
    logic             emit;
    logic             last;
    logic [AddrW-1:0] addr;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dist_done;
  } sts_t;

  function automatic logic [7:0] gray_map(input logic [3:0] lvl);
    logic [7:0] g;
    case (lvl)
      4'd0, 4'd1, 4'd2, 4'd3: g = 8'd255;
      4'd4: g = 8'd233;
      4'd5: g = 8'd176;
      4'd6: g = 8'd130;
      4'd7: g = 8'd90;
      4'd8: g = 8'd56;
      4'd9: g = 8'd26;
      default: g = 8'd0;
    endcase
    return g;
  endfunction

endpackage

[rtl/core/cdwm_ram.sv]
// ----------------------------------------------------------------------------
// cdwm_ram: generic single-port RAM
// One address per cycle, written and read together; registered read data returns the old contents.
// ----------------------------------------------------------------------------
module cdwm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/core/cdwm_dist.sv]
// ----------------------------------------------------------------------------
// cdwm_dist: weighted color distance unit
// Products are registered, the ratio comes from a restoring divider
// (one quotient bit a cycle, 25 steps), the root from a bit-by-bit
// square root (13 steps).
// ----------------------------------------------------------------------------
module cdwm_dist
  import cdwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cfg_t        cfg,
  input  logic [7:0]  c0,
  input  logic [7:0]  c1,
  input  logic [7:0]  c2,
  output logic        done,
  output logic [12:0] dist_q
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_ROOT  = 3'd6;

  logic [2:0]  state;
  logic [4:0]  cnt;
  logic [7:0]  e0, e1, e2;
  logic [15:0] q0, q1, q2;
  logic [23:0] p0, p1, p2;       // w * diff^2
  logic [38:0] t0, t1, t2;       // scaled terms, sum <= den < 2^39
  logic [38:0] den;              // 527152500 * S < 2^39
  logic [39:0] rem;
  logic [24:0] quo;              // <= 2^24
  logic [9:0]  wsum;
  logic [8:0]  d0, d1, d2, h;
  logic [39:0] step;
  logic [12:0] root_try;
  logic [25:0] root_sq;

  always_comb begin
    d0 = (c0 > cfg.ref_col[7:0])   ? {1'b0, c0 - cfg.ref_col[7:0]}
                                   : {1'b0, cfg.ref_col[7:0] - c0};
    d1 = (c1 > cfg.ref_col[15:8])  ? {1'b0, c1 - cfg.ref_col[15:8]}
                                   : {1'b0, cfg.ref_col[15:8] - c1};
    d2 = (c2 > cfg.ref_col[23:16]) ? {1'b0, c2 - cfg.ref_col[23:16]}
                                   : {1'b0, cfg.ref_col[23:16] - c2};
    if (!cfg.mode || d0 <= 9'd90) h = d0;
    else if (d0 <= 9'd180)        h = 9'd180 - d0;
    else                          h = d0 - 9'd180;
    wsum     = {2'b0, cfg.w0} + {2'b0, cfg.w1} + {2'b0, cfg.w2};
    // first step takes the integer bit, the rest shift in fraction bits
    step     = (cnt == 5'd0) ? rem : {rem[38:0], 1'b0};
    root_try = dist_q | (13'd1 << cnt[3:0]);
    root_sq  = root_try * root_try;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            e0 <= h[7:0]; e1 <= d1[7:0]; e2 <= d2[7:0];
            den <= 39'd527152500 * 39'(wsum);
            state <= S_SQ;
          end
        end
        S_SQ: begin
          q0 <= e0 * e0; q1 <= e1 * e1; q2 <= e2 * e2;
          state <= S_MUL;
        end
        S_MUL: begin
          p0 <= cfg.w0 * q0; p1 <= cfg.w1 * q1; p2 <= cfg.w2 * q2;
          state <= S_SCALE;
        end
        S_SCALE: begin
          t0 <= cfg.mode ? 39'(p0) * 39'd65025 : 39'(p0) * 39'd8100;
          t1 <= 39'(p1) * 39'd8100;
          t2 <= 39'(p2) * 39'd8100;
          state <= S_SUM;
        end
        S_SUM: begin
          rem    <= 40'(t0) + 40'(t1) + 40'(t2);
          quo    <= '0;
          cnt    <= 5'd0;
          dist_q <= '0;
          if (wsum == 10'd0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else state <= S_DIV;
        end
        S_DIV: begin
          // quotient = floor(num * 2^24 / den); num <= den keeps it <= 2^24
          if (step >= 40'(den)) begin
            rem <= step - 40'(den);
            quo <= {quo[23:0], 1'b1};
          end else begin
            rem <= step;
            quo <= {quo[23:0], 1'b0};
          end
          if (cnt == 5'd24) begin
            cnt   <= 5'd12;
            state <= S_ROOT;
          end else cnt <= cnt + 5'd1;
        end
        S_ROOT: begin
          if ({1'b0, quo} >= root_sq) dist_q <= root_try;
          if (cnt == 5'd0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else cnt <= cnt - 5'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/cdwm_datapath.sv]
// ----------------------------------------------------------------------------
// cdwm_datapath: line stores, window and gray mapping
// ----------------------------------------------------------------------------
module cdwm_datapath
  import cdwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [23:0] pix,
  output logic [7:0]  gray,
  output logic        last
);
  logic             dist_done;
  logic [DistW-1:0] dist_q, ra, rb, dval;
  logic [ColW-1:0]  w1, w2, colsum;
  logic [TotW-1:0]  total;
  logic [20:0]      scaled;
  logic [3:0]       lvl;

  // pixel is taken straight off the bus at the accepting edge
  cdwm_dist u_dist (
    .clk, .rst, .start(cmd.start & ~cmd.pad), .cfg,
    .c0(pix[7:0]), .c1(pix[15:8]), .c2(pix[23:16]), .done(dist_done), .dist_q
  );
  assign sts.dist_done = dist_done;

  assign dval = cmd.pad ? OneQ12 : dist_q;

  cdwm_ram #(.Width(DistW), .Depth(LineDepth)) u_line_a (
    .clk, .we(cmd.commit), .addr(cmd.addr), .wdata(dval), .rdata(ra)
  );
  cdwm_ram #(.Width(DistW), .Depth(LineDepth)) u_line_b (
    .clk, .we(cmd.commit), .addr(cmd.addr), .wdata(ra), .rdata(rb)
  );

  always_comb begin
    colsum = ColW'(cmd.top_valid ? rb : OneQ12) + ColW'(ra) + ColW'(dval);
    total  = TotW'(cmd.col_zero ? ColW'(3 * 4096) : w1)
           + TotW'(cmd.col_zero ? ColW'(3 * 4096) : w2) + TotW'(colsum);
    scaled = 21'(total) * 21'd10;
    // divide by 36864 = 9 * 4096: compare chain against its multiples
    lvl = 4'd10;
    for (int i = 10; i >= 1; i--) begin
      if (scaled < 21'(i * 36864)) lvl = 4'(i - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w1 <= '0; w2 <= '0;
    end else if (cmd.commit) begin
      w1 <= cmd.col_zero ? ColW'(3 * 4096) : w2;
      w2 <= colsum;
      if (cmd.emit) begin
        gray <= gray_map(lvl);
        last <= cmd.last;
      end
    end
  end
endmodule

[rtl/core/cdwm_ctrl.sv]
// ----------------------------------------------------------------------------
// cdwm_ctrl: sequencer and raster position
// ----------------------------------------------------------------------------
module cdwm_ctrl
  import cdwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [10:0] fw,
  input  logic [12:0] fh,
  input  logic        in_beat,
  output logic        in_ready,
  input  sts_t        sts,
  output cmd_t        cmd,
  output logic        out_valid,
  input  logic        out_ready
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_WR   = 2'd3;

  logic [1:0]  state, state_next;
  logic [12:0] row;
  logic [10:0] col;
  logic [10:0] w;
  logic        row_end, pad, emit, commit, out_busy, out_valid_next;

  assign w        = (fw > 11'(MaxWidth)) ? 11'(MaxWidth) : fw;
  assign row_end  = col >= w;
  assign pad      = row_end || row >= fh;
  assign emit     = row != 13'd0 && col != 11'd0;
  // result register still occupied after this edge
  assign out_busy = out_valid && !out_ready;
  // write step holds while a new result would overwrite a waiting one
  assign commit   = (state == S_WR) && !(emit && out_busy);
  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd.start     = in_beat;
    cmd.commit    = commit;
    cmd.pad       = pad;
    cmd.top_valid = row >= 13'd2;
    cmd.col_zero  = col == 11'd0;
    cmd.emit      = emit;
    cmd.last      = row_end && row >= fh;
    cmd.addr      = (col > 11'(MaxWidth)) ? AddrW'(MaxWidth) : AddrW'(col);
  end

  always_comb begin
    out_valid_next = (commit && emit) ? 1'b1 : out_busy;
    case (state)
      S_IDLE:  state_next = in_beat ? (pad ? S_RD : S_CALC) : S_IDLE;
      S_CALC:  state_next = sts.dist_done ? S_RD : S_CALC;
      S_RD:    state_next = S_WR;
      S_WR:    state_next = commit ? S_IDLE : S_WR;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; row <= '0; col <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (commit) begin
        if (row_end) begin
          col <= '0;
          row <= (row >= fh) ? '0 : row + 13'd1;
        end else col <= col + 11'd1;
      end
    end
  end
endmodule

[rtl/core/color_distance_window_map.sv]
// ----------------------------------------------------------------------------
// color_distance_window_map: 3x3 color-distance window to gray byte
// ----------------------------------------------------------------------------
// One pixel beat is taken at a time. From acceptance to the next ready, a
// pixel beat passes through squares, weights and scaling, 25 divider steps
// and 13 square-root steps in the distance unit, then the hand-off, line
// store update and window shift. A pad beat skips the distance unit and a
// pixel with all weights zero skips the divider and square root. The host
// sends frame_height+1 rows of frame_width+1 beats (pad column, pad row);
// the result for centre (r-1,c-1) leaves when (r,c) is fed. The output
// register holds a result until taken; the next beat is still accepted, and
// only its line store update waits while the previous result is held.
module color_distance_window_map
  import cdwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // chan_first, chan_second, chan_third
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // mapped gray byte
  output logic        m_tlast,   // frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  cfg_t        cfg;
  logic [10:0] fw;
  logic [12:0] fh;
  cmd_t        cmd;
  sts_t        sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{mode: 1'b0, ref_col: 24'd240, w0: 8'd24, w1: 8'd16, w2: 8'd16};
      fw  <= 11'd640;
      fh  <= 13'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MODE: cfg.mode    <= cfg_data[0];
        REG_REF:  cfg.ref_col <= cfg_data;
        REG_W0:   cfg.w0      <= cfg_data[7:0];
        REG_W1:   cfg.w1      <= cfg_data[7:0];
        REG_W2:   cfg.w2      <= cfg_data[7:0];
        REG_FW:   fw          <= cfg_data[10:0];
        REG_FH:   fh          <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  cdwm_ctrl u_ctrl (
    .clk, .rst, .fw, .fh, .in_beat(s_tvalid & s_tready), .in_ready(s_tready),
    .sts, .cmd, .out_valid(m_tvalid), .out_ready(m_tready)
  );

  cdwm_datapath u_dp (
    .clk, .rst, .cfg, .cmd, .sts, .pix(s_tdata), .gray(m_tdata), .last(m_tlast)
  );
endmodule
